// File: rtl/core/tt_pkg.sv
// ----------------------------------------------------------------------------
// tt_pkg
// Shared widths and constants for the thruster throttle pipeline.
// ----------------------------------------------------------------------------
package tt_pkg;

  localparam int COORD_WIDTH_DEF = 24;

  localparam int UNIT_W    = 18;   // signed Q2.16 unit component
  localparam int MAG_W     = 15;   // normalized magnitude
  localparam int SQR_W     = 2 * MAG_W;
  localparam int N2_W      = SQR_W + 2;
  localparam int NUM_W     = N2_W + 16;
  localparam int ROOT_W    = NUM_W / 2;
  localparam int REM_W     = ROOT_W + 2;
  localparam int DREM_W    = ROOT_W;
  localparam int Q_W       = 17;
  localparam int SQ_STEPS  = ROOT_W;
  localparam int DIV_STEPS = Q_W;

  // A..D front stages, sqrt init + steps, div init + steps, output stage
  localparam int UNIT_LAT  = 4 + (SQ_STEPS + 1) + (DIV_STEPS + 1) + 1;

  localparam int THR_W     = 17;
  localparam logic [THR_W-1:0] UNIT_ONE       = 17'h10000;
  localparam logic [THR_W-1:0] DEADBAND_RESET = 17'd655;

  localparam int DOT_P_W   = 2 * UNIT_W;
  localparam int DOT_S_W   = DOT_P_W + 2;
  localparam int INFL_W    = DOT_S_W - 16;
  localparam int TOTAL_W   = INFL_W + 1;

endpackage

// File: rtl/core/tt_delay.sv
// ----------------------------------------------------------------------------
// tt_delay
// Fixed-depth shift line that keeps side data aligned with the pipeline.
// ----------------------------------------------------------------------------
module tt_delay
  import tt_pkg::*;
#(
  parameter int WD    = 1,
  parameter int DEPTH = 1
) (
  input  logic          clk,
  input  logic [WD-1:0] in_d,
  output logic [WD-1:0] out_d
);

  logic [WD-1:0] line_r [DEPTH];

  always_ff @(posedge clk) begin
    line_r[0] <= in_d;
    for (int k = 1; k < DEPTH; k++) begin
      line_r[k] <= line_r[k-1];
    end
  end

  assign out_d = line_r[DEPTH-1];

endmodule

// File: rtl/core/tt_unit.sv
// ----------------------------------------------------------------------------
// tt_unit
// Pipelined 3-vector normalizer: magnitude scaling, squared length,
// bit-per-stage square root and bit-per-stage division, to signed Q2.16.
// ----------------------------------------------------------------------------
module tt_unit
  import tt_pkg::*;
#(
  parameter int IW = COORD_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_vld,
  input  logic signed [IW-1:0]     in_c  [3],
  output logic                     out_vld,
  output logic signed [UNIT_W-1:0] out_u [3]
);

  localparam int PW = $clog2(IW);

  // stage A: magnitude and sign
  logic [IW-1:0] a_mag_r [3];
  logic [IW-1:0] a_mag_nxt [3];
  logic [2:0]    a_neg_r;
  logic          a_vld_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a_mag_nxt[i] = in_c[i][IW-1] ? $unsigned(-in_c[i]) : $unsigned(in_c[i]);
    end
  end

  // stage B: leading one of the largest magnitude
  logic [IW-1:0] b_mag_r [3];
  logic [2:0]    b_neg_r;
  logic          b_zero_r;
  logic [PW-1:0] b_pos_r;
  logic          b_vld_r;
  logic [IW-1:0] b_or;
  logic [PW-1:0] b_pos_nxt;

  always_comb begin
    b_or      = a_mag_r[0] | a_mag_r[1] | a_mag_r[2];
    b_pos_nxt = '0;
    for (int j = 0; j < IW; j++) begin
      if (b_or[j]) begin
        b_pos_nxt = PW'(j);
      end
    end
  end

  // stage C: scale so the largest magnitude sits in [2^14, 2^15)
  logic [MAG_W-1:0] c_mag_r [3];
  logic [MAG_W-1:0] c_mag_nxt [3];
  logic [2:0]       c_neg_r;
  logic             c_zero_r;
  logic             c_vld_r;
  logic [IW-1:0]    c_shl [3];
  logic [IW-1:0]    c_shr [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c_shl[i] = b_mag_r[i] << (PW'(MAG_W - 1) - b_pos_r);
      c_shr[i] = b_mag_r[i] >> (b_pos_r - PW'(MAG_W - 1));
      c_mag_nxt[i] = (b_pos_r >= PW'(MAG_W - 1)) ? c_shr[i][MAG_W-1:0]
                                                 : c_shl[i][MAG_W-1:0];
    end
  end

  // stage D: squares
  logic [SQR_W-1:0] d_sq_r [3];
  logic [MAG_W-1:0] d_mag_r [3];
  logic [2:0]       d_neg_r;
  logic             d_zero_r;
  logic             d_vld_r;

  // square root stages; index 0 is the load of n2 << 16
  logic [NUM_W-1:0]  sq_num_r  [SQ_STEPS+1];
  logic [REM_W-1:0]  sq_rem_r  [SQ_STEPS+1];
  logic [ROOT_W-1:0] sq_root_r [SQ_STEPS+1];
  logic [MAG_W-1:0]  sq_mag_r  [SQ_STEPS+1][3];
  logic [2:0]        sq_neg_r  [SQ_STEPS+1];
  logic              sq_zero_r [SQ_STEPS+1];
  logic              sq_vld_r  [SQ_STEPS+1];

  // division stages; index 0 is the load of mag << 7
  logic [DREM_W-1:0] dv_rem_r  [DIV_STEPS+1][3];
  logic [Q_W-1:0]    dv_q_r    [DIV_STEPS+1][3];
  logic [ROOT_W-1:0] dv_len_r  [DIV_STEPS+1];
  logic [2:0]        dv_neg_r  [DIV_STEPS+1];
  logic              dv_zero_r [DIV_STEPS+1];
  logic              dv_vld_r  [DIV_STEPS+1];

  logic [N2_W-1:0] e_n2;

  assign e_n2 = N2_W'(d_sq_r[0]) + N2_W'(d_sq_r[1]) + N2_W'(d_sq_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r      <= 1'b0;
      b_vld_r      <= 1'b0;
      c_vld_r      <= 1'b0;
      d_vld_r      <= 1'b0;
      sq_vld_r[0]  <= 1'b0;
      dv_vld_r[0]  <= 1'b0;
    end else begin
      a_vld_r      <= in_vld;
      b_vld_r      <= a_vld_r;
      c_vld_r      <= b_vld_r;
      d_vld_r      <= c_vld_r;
      sq_vld_r[0]  <= d_vld_r;
      dv_vld_r[0]  <= sq_vld_r[SQ_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    a_neg_r   <= {in_c[2][IW-1], in_c[1][IW-1], in_c[0][IW-1]};
    b_neg_r   <= a_neg_r;
    b_zero_r  <= (b_or == '0);
    b_pos_r   <= b_pos_nxt;
    c_neg_r   <= b_neg_r;
    c_zero_r  <= b_zero_r;
    d_neg_r   <= c_neg_r;
    d_zero_r  <= c_zero_r;
    sq_num_r[0]  <= {e_n2, 16'b0};
    sq_rem_r[0]  <= '0;
    sq_root_r[0] <= '0;
    sq_neg_r[0]  <= d_neg_r;
    sq_zero_r[0] <= d_zero_r;
    dv_len_r[0]  <= sq_root_r[SQ_STEPS];
    dv_neg_r[0]  <= sq_neg_r[SQ_STEPS];
    dv_zero_r[0] <= sq_zero_r[SQ_STEPS];
    for (int i = 0; i < 3; i++) begin
      a_mag_r[i]     <= a_mag_nxt[i];
      b_mag_r[i]     <= a_mag_r[i];
      c_mag_r[i]     <= c_mag_nxt[i];
      d_mag_r[i]     <= c_mag_r[i];
      d_sq_r[i]      <= SQR_W'(c_mag_r[i]) * SQR_W'(c_mag_r[i]);
      sq_mag_r[0][i] <= d_mag_r[i];
      dv_rem_r[0][i] <= {2'b0, sq_mag_r[SQ_STEPS][i], 7'b0};
      dv_q_r[0][i]   <= '0;
    end
  end

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    logic [REM_W:0] rem2;
    logic [REM_W:0] trial;
    logic           take;

    assign rem2  = {sq_rem_r[k][REM_W-2:0], sq_num_r[k][NUM_W-1 -: 2]};
    assign trial = {1'b0, sq_root_r[k], 2'b01};
    assign take  = (rem2 >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_vld_r[k+1] <= 1'b0;
      end else begin
        sq_vld_r[k+1] <= sq_vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      sq_num_r[k+1]  <= {sq_num_r[k][NUM_W-3:0], 2'b0};
      sq_rem_r[k+1]  <= take ? REM_W'(rem2 - trial) : REM_W'(rem2);
      sq_root_r[k+1] <= {sq_root_r[k][ROOT_W-2:0], take};
      sq_mag_r[k+1]  <= sq_mag_r[k];
      sq_neg_r[k+1]  <= sq_neg_r[k];
      sq_zero_r[k+1] <= sq_zero_r[k];
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic [DREM_W:0] r2   [3];
    logic [2:0]      take;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        r2[i]   = {dv_rem_r[k][i], 1'b0};
        take[i] = (r2[i] >= {1'b0, dv_len_r[k]});
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[k+1] <= 1'b0;
      end else begin
        dv_vld_r[k+1] <= dv_vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      dv_len_r[k+1]  <= dv_len_r[k];
      dv_neg_r[k+1]  <= dv_neg_r[k];
      dv_zero_r[k+1] <= dv_zero_r[k];
      for (int i = 0; i < 3; i++) begin
        dv_rem_r[k+1][i] <= take[i] ? DREM_W'(r2[i] - {1'b0, dv_len_r[k]})
                                    : DREM_W'(r2[i]);
        dv_q_r[k+1][i]   <= {dv_q_r[k][i][Q_W-2:0], take[i]};
      end
    end
  end

  // output stage: clamp, sign, zero vector
  logic                     o_vld_r;
  logic signed [UNIT_W-1:0] o_u_r   [3];
  logic signed [UNIT_W-1:0] o_u_nxt [3];
  logic [Q_W-1:0]           o_qc    [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      o_qc[i] = (dv_q_r[DIV_STEPS][i] > UNIT_ONE) ? UNIT_ONE : dv_q_r[DIV_STEPS][i];
      if (dv_zero_r[DIV_STEPS]) begin
        o_u_nxt[i] = '0;
      end else if (dv_neg_r[DIV_STEPS][i]) begin
        o_u_nxt[i] = -$signed({1'b0, o_qc[i]});
      end else begin
        o_u_nxt[i] = $signed({1'b0, o_qc[i]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else begin
      o_vld_r <= dv_vld_r[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      o_u_r[i] <= o_u_nxt[i];
    end
  end

  assign out_vld = o_vld_r;
  assign out_u   = o_u_r;

endmodule

// File: rtl/core/thruster_throttle_from_command.sv
// ----------------------------------------------------------------------------
// thruster_throttle_from_command
// Throttle of one thruster from its geometry and the motion command.
// ----------------------------------------------------------------------------
// Path from start to out_valid: nozzle normalizer, cross product, torque normalizer, dot products and clamp.
// Throughput: one word per cycle; busy is always low, no stall path.
// The rate is set by the normalizer pipelines (sqrt and divide, one bit a stage).
// Reset: synchronous, active low; clears all valid bits, deadband back to 655.
module thruster_throttle_from_command
  import tt_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] in_offset_x,
  input  logic signed [COORD_WIDTH-1:0] in_offset_y,
  input  logic signed [COORD_WIDTH-1:0] in_offset_z,
  input  logic signed [COORD_WIDTH-1:0] in_nozzle_x,
  input  logic signed [COORD_WIDTH-1:0] in_nozzle_y,
  input  logic signed [COORD_WIDTH-1:0] in_nozzle_z,
  input  logic signed [COORD_WIDTH-1:0] in_move_x,
  input  logic signed [COORD_WIDTH-1:0] in_move_y,
  input  logic signed [COORD_WIDTH-1:0] in_move_z,
  input  logic signed [COORD_WIDTH-1:0] in_turn_x,
  input  logic signed [COORD_WIDTH-1:0] in_turn_y,
  input  logic signed [COORD_WIDTH-1:0] in_turn_z,
  input  logic                          cfg_we,
  input  logic [THR_W-1:0]              cfg_wdata,
  output logic                          out_valid,
  output logic [THR_W-1:0]              out_throttle
);

  localparam int W    = COORD_WIDTH;
  localparam int PR_W = W + UNIT_W;
  localparam int TQ_W = PR_W + 1;

  logic [THR_W-1:0] deadband_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadband_r <= DEADBAND_RESET;
    end else if (cfg_we) begin
      deadband_r <= cfg_wdata;
    end
  end

  assign busy = 1'b0;

  // nozzle normalizer
  logic signed [W-1:0]      nz_in [3];
  logic                     nz_vld;
  logic signed [UNIT_W-1:0] nz_u  [3];

  assign nz_in[0] = in_nozzle_x;
  assign nz_in[1] = in_nozzle_y;
  assign nz_in[2] = in_nozzle_z;

  tt_unit #(.IW(W)) u_unit_nz (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (start),
    .in_c    (nz_in),
    .out_vld (nz_vld),
    .out_u   (nz_u)
  );

  logic [3*W-1:0]      off_dly;
  logic signed [W-1:0] off_d [3];

  tt_delay #(.WD(3 * W), .DEPTH(UNIT_LAT)) u_dly_off (
    .clk   (clk),
    .in_d  ({in_offset_z, in_offset_y, in_offset_x}),
    .out_d (off_dly)
  );

  assign off_d[0] = $signed(off_dly[0 +: W]);
  assign off_d[1] = $signed(off_dly[W +: W]);
  assign off_d[2] = $signed(off_dly[2*W +: W]);

  // cross product offset x thrust
  logic signed [UNIT_W-1:0] thrn     [3];
  logic                     x1_vld_r;
  logic signed [UNIT_W-1:0] x1_thr_r [3];
  logic signed [PR_W-1:0]   x1_p_r   [6];
  logic                     x2_vld_r;
  logic signed [UNIT_W-1:0] x2_thr_r [3];
  logic signed [TQ_W-1:0]   x2_tq_r  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      thrn[i] = -nz_u[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x1_vld_r <= 1'b0;
      x2_vld_r <= 1'b0;
    end else begin
      x1_vld_r <= nz_vld;
      x2_vld_r <= x1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    x1_p_r[0]  <= PR_W'(off_d[1]) * PR_W'(thrn[2]);
    x1_p_r[1]  <= PR_W'(off_d[2]) * PR_W'(thrn[1]);
    x1_p_r[2]  <= PR_W'(off_d[2]) * PR_W'(thrn[0]);
    x1_p_r[3]  <= PR_W'(off_d[0]) * PR_W'(thrn[2]);
    x1_p_r[4]  <= PR_W'(off_d[0]) * PR_W'(thrn[1]);
    x1_p_r[5]  <= PR_W'(off_d[1]) * PR_W'(thrn[0]);
    x2_tq_r[0] <= TQ_W'(x1_p_r[0]) - TQ_W'(x1_p_r[1]);
    x2_tq_r[1] <= TQ_W'(x1_p_r[2]) - TQ_W'(x1_p_r[3]);
    x2_tq_r[2] <= TQ_W'(x1_p_r[4]) - TQ_W'(x1_p_r[5]);
    for (int i = 0; i < 3; i++) begin
      x1_thr_r[i] <= thrn[i];
      x2_thr_r[i] <= x1_thr_r[i];
    end
  end

  // command vectors wait for the torque
  logic [6*W-1:0]      cmd_dly;
  logic signed [W-1:0] mv_in [3];
  logic signed [W-1:0] tn_in [3];

  tt_delay #(.WD(6 * W), .DEPTH(UNIT_LAT + 2)) u_dly_cmd (
    .clk   (clk),
    .in_d  ({in_turn_z, in_turn_y, in_turn_x, in_move_z, in_move_y, in_move_x}),
    .out_d (cmd_dly)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mv_in[i] = $signed(cmd_dly[i*W +: W]);
      tn_in[i] = $signed(cmd_dly[(3+i)*W +: W]);
    end
  end

  logic                     tq_vld;
  logic                     mv_vld;
  logic                     tn_vld;
  logic signed [UNIT_W-1:0] tq_u [3];
  logic signed [UNIT_W-1:0] mv_u [3];
  logic signed [UNIT_W-1:0] tn_u [3];

  tt_unit #(.IW(TQ_W)) u_unit_tq (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (x2_vld_r),
    .in_c    (x2_tq_r),
    .out_vld (tq_vld),
    .out_u   (tq_u)
  );

  tt_unit #(.IW(W)) u_unit_mv (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (x2_vld_r),
    .in_c    (mv_in),
    .out_vld (mv_vld),
    .out_u   (mv_u)
  );

  tt_unit #(.IW(W)) u_unit_tn (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (x2_vld_r),
    .in_c    (tn_in),
    .out_vld (tn_vld),
    .out_u   (tn_u)
  );

  logic [3*UNIT_W-1:0]      thr_dly;
  logic signed [UNIT_W-1:0] thr_d [3];

  tt_delay #(.WD(3 * UNIT_W), .DEPTH(UNIT_LAT)) u_dly_thr (
    .clk   (clk),
    .in_d  ({x2_thr_r[2], x2_thr_r[1], x2_thr_r[0]}),
    .out_d (thr_dly)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      thr_d[i] = $signed(thr_dly[i*UNIT_W +: UNIT_W]);
    end
  end

  // dot products, truncation, deadband and clamp
  logic                      d1_vld_r;
  logic signed [DOT_P_W-1:0] d1_rot_r [3];
  logic signed [DOT_P_W-1:0] d1_tra_r [3];
  logic                      d2_vld_r;
  logic signed [DOT_S_W-1:0] d2_rot_r;
  logic signed [DOT_S_W-1:0] d2_tra_r;
  logic                      d3_vld_r;
  logic signed [TOTAL_W-1:0] d3_total_r;
  logic signed [DOT_S_W-1:0] rot_adj;
  logic signed [DOT_S_W-1:0] tra_adj;
  logic signed [INFL_W-1:0]  rot_q;
  logic signed [INFL_W-1:0]  tra_q;
  logic                      out_valid_r;
  logic [THR_W-1:0]          out_throttle_r;
  logic [THR_W-1:0]          out_throttle_nxt;
  logic signed [TOTAL_W-1:0] deadband_s;

  always_comb begin
    rot_adj = d2_rot_r + (d2_rot_r[DOT_S_W-1] ? DOT_S_W'(65535) : DOT_S_W'(0));
    tra_adj = d2_tra_r + (d2_tra_r[DOT_S_W-1] ? DOT_S_W'(65535) : DOT_S_W'(0));
    rot_q   = rot_adj[DOT_S_W-1:16];
    tra_q   = tra_adj[DOT_S_W-1:16];
  end

  assign deadband_s = $signed(TOTAL_W'(deadband_r));

  always_comb begin
    if (d3_total_r < deadband_s) begin
      out_throttle_nxt = '0;
    end else if (d3_total_r > $signed(TOTAL_W'(UNIT_ONE))) begin
      out_throttle_nxt = UNIT_ONE;
    end else if (d3_total_r[TOTAL_W-1]) begin
      out_throttle_nxt = '0;
    end else begin
      out_throttle_nxt = d3_total_r[THR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_vld_r    <= 1'b0;
      d2_vld_r    <= 1'b0;
      d3_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      d1_vld_r    <= tq_vld;
      d2_vld_r    <= d1_vld_r;
      d3_vld_r    <= d2_vld_r;
      out_valid_r <= d3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      d1_rot_r[i] <= DOT_P_W'(tq_u[i]) * DOT_P_W'(tn_u[i]);
      d1_tra_r[i] <= DOT_P_W'(thr_d[i]) * DOT_P_W'(mv_u[i]);
    end
    d2_rot_r       <= DOT_S_W'(d1_rot_r[0]) + DOT_S_W'(d1_rot_r[1]) + DOT_S_W'(d1_rot_r[2]);
    d2_tra_r       <= DOT_S_W'(d1_tra_r[0]) + DOT_S_W'(d1_tra_r[1]) + DOT_S_W'(d1_tra_r[2]);
    d3_total_r     <= TOTAL_W'(rot_q) + TOTAL_W'(tra_q);
    out_throttle_r <= out_throttle_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_throttle = out_throttle_r;

`ifndef NO_ASSERTIONS
  a_units_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (tq_vld == mv_vld) && (tq_vld == tn_vld))
    else $error("normalizer pipelines out of step");

  a_throttle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_throttle <= UNIT_ONE))
    else $error("throttle above full thrust");

  a_deadband_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_throttle != '0) && !$past(cfg_we)) |->
      ((out_throttle >= deadband_r) || (out_throttle == UNIT_ONE)))
    else $error("thruster fired below deadband");
`endif

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for thruster_throttle_from_command. Words carrying
// thruster geometry and command vectors are sent with random gaps, and each
// throttle is checked against a fixed-point model of the normalizers, dot
// products, deadband and clamp. Deadband is rewritten between phases.
// ----------------------------------------------------------------------------
module testbench;
  import tt_pkg::*;

  localparam int CW = COORD_WIDTH_DEF;
  localparam int SETTLE = 2 * UNIT_LAT + 30;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [CW-1:0] ONE = 1 <<< 12;

  typedef logic signed [CW-1:0] coord_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  coord_t word_in [12];
  logic cfg_we = 1'b0;
  logic [THR_W-1:0] cfg_wdata = '0;
  logic out_valid;
  logic [THR_W-1:0] out_throttle;

  logic [THR_W-1:0] deadband_copy = DEADBAND_RESET;
  logic [THR_W-1:0] throttle_q [$];
  int fails = 0;
  int idle_cycles = 0;
  bit gaps_on = 1'b1;

  initial for (int i = 0; i < 12; i++) word_in[i] = '0;

  always #4 clk = ~clk;

  thruster_throttle_from_command dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_offset_x(word_in[0]), .in_offset_y(word_in[1]), .in_offset_z(word_in[2]),
    .in_nozzle_x(word_in[3]), .in_nozzle_y(word_in[4]), .in_nozzle_z(word_in[5]),
    .in_move_x(word_in[6]), .in_move_y(word_in[7]), .in_move_z(word_in[8]),
    .in_turn_x(word_in[9]), .in_turn_y(word_in[10]), .in_turn_z(word_in[11]),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .out_valid(out_valid), .out_throttle(out_throttle)
  );

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  task automatic normalize(input longint v[3], output longint u[3]);
    longint unsigned mag[3], m, n2, len, q;
    bit neg[3];
    m = 0;
    n2 = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = v[i] < 0;
      mag[i] = neg[i] ? -v[i] : v[i];
      if (mag[i] > m) m = mag[i];
    end
    if (m == 0) begin
      for (int i = 0; i < 3; i++) u[i] = 0;
      return;
    end
    while (m >= (64'd1 << 15)) begin
      m >>= 1;
      for (int i = 0; i < 3; i++) mag[i] >>= 1;
    end
    while (m < (64'd1 << 14)) begin
      m <<= 1;
      for (int i = 0; i < 3; i++) mag[i] <<= 1;
    end
    for (int i = 0; i < 3; i++) n2 += mag[i] * mag[i];
    len = int_sqrt(n2 << 16);
    for (int i = 0; i < 3; i++) begin
      q = (mag[i] << 24) / len;
      if (q > 65536) q = 65536;
      u[i] = neg[i] ? -longint'(q) : longint'(q);
    end
  endtask

  function automatic longint influence(input longint a[3], input longint b[3]);
    return (a[0] * b[0] + a[1] * b[1] + a[2] * b[2]) / 65536;
  endfunction

  task automatic predict_throttle(input coord_t w[12], output logic [THR_W-1:0] thr_out);
    longint off[3], noz[3], mv[3], tn[3], thr[3], tq[3], utq[3], umv[3], utn[3];
    longint total;
    for (int i = 0; i < 3; i++) begin
      off[i] = w[i];
      noz[i] = w[3 + i];
      mv[i] = w[6 + i];
      tn[i] = w[9 + i];
    end
    normalize(noz, thr);
    for (int i = 0; i < 3; i++) thr[i] = -thr[i];
    tq[0] = off[1] * thr[2] - off[2] * thr[1];
    tq[1] = off[2] * thr[0] - off[0] * thr[2];
    tq[2] = off[0] * thr[1] - off[1] * thr[0];
    normalize(tq, utq);
    normalize(tn, utn);
    normalize(mv, umv);
    total = influence(utq, utn) + influence(thr, umv);
    if (total < longint'(deadband_copy)) thr_out = '0;
    else if (total > 65536) thr_out = UNIT_ONE;
    else if (total < 0) thr_out = '0;
    else thr_out = total[THR_W-1:0];
  endtask

  task automatic report(input string what);
    $display("tb: mismatch: %s", what);
    fails++;
  endtask

  // caller sits at a rising edge
  task automatic send_word(input coord_t w[12]);
    logic [THR_W-1:0] e;
    start <= 1'b1;
    for (int i = 0; i < 12; i++) word_in[i] <= w[i];
    do @(posedge clk); while (busy);
    predict_throttle(w, e);
    throttle_q.push_back(e);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic drain;
    start <= 1'b0;
    while (throttle_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_deadband(input logic [THR_W-1:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    deadband_copy = val;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (throttle_q.size() == 0) begin
        report($sformatf("unexpected throttle %0d", out_throttle));
      end else begin
        if (out_throttle !== throttle_q[0])
          report($sformatf("throttle %0d, want %0d", out_throttle, throttle_q[0]));
        void'(throttle_q.pop_front());
      end
    end
    if (rst_n && ((start && !busy) || out_valid)) idle_cycles <= 0;
    else if (rst_n) idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return CMAX;
      2: return CMIN;
      3: return coord_t'($signed($urandom_range(0, 16)) - 8);
      4: return coord_t'($signed($urandom_range(0, 2 * ONE)) - ONE);
      default: return coord_t'($urandom);
    endcase
  endfunction

  task automatic send_vecs(input coord_t o[3], input coord_t n[3],
                           input coord_t m[3], input coord_t t[3]);
    coord_t w[12];
    for (int i = 0; i < 3; i++) begin
      w[i] = o[i];
      w[3 + i] = n[i];
      w[6 + i] = m[i];
      w[9 + i] = t[i];
    end
    send_word(w);
  endtask

  task automatic test_directed;
    coord_t z[3] = '{0, 0, 0};
    coord_t px[3] = '{ONE, 0, 0};
    coord_t nx[3] = '{-ONE, 0, 0};
    coord_t py[3] = '{0, ONE, 0};
    coord_t pz[3] = '{0, 0, ONE};
    coord_t nz[3] = '{0, 0, -ONE};
    coord_t hi[3] = '{CMAX, CMAX, CMAX};
    coord_t lo[3] = '{CMIN, CMIN, CMIN};
    coord_t mix[3] = '{CMAX, CMIN, 1};
    coord_t tiny[3] = '{1, -1, 0};
    send_vecs(z, z, z, z);
    send_vecs(py, z, px, pz);
    send_vecs(py, nx, px, pz);
    send_vecs(py, nx, px, nz);
    send_vecs(py, nx, nx, z);
    send_vecs(px, nx, z, pz);
    send_vecs(z, nx, px, pz);
    send_vecs(hi, lo, hi, hi);
    send_vecs(lo, hi, lo, lo);
    send_vecs(mix, tiny, mix, tiny);
    send_vecs(tiny, mix, tiny, mix);
    send_vecs(hi, tiny, lo, mix);
    send_vecs(py, nx, '{ONE, 1, 0}, z);
    send_vecs(py, nx, '{ONE, ONE / 8, 0}, z);
    send_vecs(py, nx, '{ONE, ONE * 50, 0}, '{0, ONE, ONE * 40});
  endtask

  task automatic test_random(input int count);
    coord_t w[12];
    for (int k = 0; k < count; k++) begin
      for (int i = 0; i < 12; i++) w[i] = rand_coord();
      send_word(w);
    end
  endtask

  task automatic test_deadband_sweep;
    write_deadband(17'd0);
    test_directed();
    test_random(300);
    write_deadband(UNIT_ONE);
    test_directed();
    test_random(300);
    write_deadband(17'h1FFFF);
    test_random(150);
    write_deadband(17'd1);
    test_random(300);
    write_deadband(17'($urandom_range(0, 65536)));
    test_random(300);
    write_deadband(17'd32768);
    test_random(300);
    write_deadband(DEADBAND_RESET);
    gaps_on = 1'b0;
    test_random(200);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(150);
    test_deadband_sweep();
    drain();
    repeat (SETTLE) @(posedge clk);
    if (fails == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
